// ===== rtl/core/gsa_pkg.sv =====
package gsa_pkg;

  localparam int unsigned SlotsDef   = 64;
  localparam int unsigned GenBitsDef = 16;
  localparam int unsigned OpW        = 3;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned GenOutW    = 16;
  localparam int unsigned StatusW    = 2;

  typedef enum logic [OpW-1:0] {
    OP_SPAWN     = 3'd0,
    OP_LOOKUP    = 3'd1,
    OP_KILL      = 3'd2,
    OP_DEFER     = 3'd3,
    OP_END_FRAME = 3'd4,
    OP_KILL_ALL  = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOTHING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SWEEP = 2'd2
  } state_e;

endpackage

// ===== rtl/core/gsa_gen_ram.sv =====
module gsa_gen_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/generational_slot_allocator.sv =====
// Generational handle table. A request is taken when start is high and busy is low;
// each result shows on the result ports for one cycle with done_o high, and the
// receiver cannot hold it off. Spawn, lookup, kill, deferred kill, unknown codes and
// a sweep that finds nothing pass through the execute state: the generation memory is read
// at the request edge, a spawn writes the new generation from that state, and the next
// request may follow at once while the result is shown. A sweep that kills slots gives
// one result per cycle, in ascending slot order. Slot state is ready right after reset;
// there is no clearing pass.
module generational_slot_allocator #(
  parameter int unsigned SLOTS    = gsa_pkg::SlotsDef,
  parameter int unsigned GEN_BITS = gsa_pkg::GenBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [gsa_pkg::OpW-1:0]     operation_i,
  input  logic [gsa_pkg::SlotW-1:0]   slot_index_i,
  input  logic [gsa_pkg::GenOutW-1:0] handle_generation_i,
  output logic                        done_o,
  output logic [gsa_pkg::StatusW-1:0] status_o,
  output logic [gsa_pkg::SlotW-1:0]   result_slot_o,
  output logic [gsa_pkg::GenOutW-1:0] result_generation_o,
  output logic                        last_o
);

  import gsa_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned HwW  = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (GEN_BITS > GenOutW) ? GEN_BITS : GenOutW;

  state_e state_q, state_d;
  op_e    op_q, op_in;

  logic [SlotW-1:0]    slot_q;
  logic [GenOutW-1:0]  hgen_q;
  logic [IdxW-1:0]     tgt_q;
  logic                reuse_q;
  logic [SLOTS-1:0]    alive_q, marked_q, sel_q;
  logic [HwW-1:0]      hw_q;
  logic                pend_q, pend_last_q;
  logic [IdxW-1:0]     pend_slot_q;

  logic                done_q, last_q;
  status_e             status_q;
  logic [SlotW-1:0]    rslot_q;
  logic [GenOutW-1:0]  rgen_q;

  logic                accept, issue;
  logic [SLOTS-1:0]    below_hw, free_vec, sel_in, sel_rest;
  logic [IdxW-1:0]     free_idx, sel_idx;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [GEN_BITS-1:0] ram_wdata, ram_rdata, gen_inc;
  logic [CmpW-1:0]     rd_ext, hgen_ext, inc_ext;

  logic                handle_ok, can_append;
  logic [IdxW-1:0]     slot_idx, hw_idx;
  status_e             exec_status;
  logic [SlotW-1:0]    exec_slot;
  logic [GenOutW-1:0]  exec_gen;

  assign op_in  = op_e'(operation_i);
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state_q == S_SWEEP) && (sel_q != '0);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      below_hw[i] = (HwW'(i) < hw_q) && (i != 0);
    end
    free_vec = ~alive_q & below_hw;
    sel_in   = alive_q & ((op_in == OP_END_FRAME) ? marked_q : '1);
    free_idx = '0;
    sel_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = IdxW'(i);
      if (sel_q[i])    sel_idx  = IdxW'(i);
    end
    sel_rest          = sel_q;
    sel_rest[sel_idx] = 1'b0;
  end

  gsa_gen_ram #(
    .Depth (SLOTS),
    .Width (GEN_BITS),
    .AddrW (IdxW)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_idx   = slot_q[IdxW-1:0];
  assign hw_idx     = hw_q[IdxW-1:0];
  assign can_append = (hw_q < HwW'(SLOTS));
  assign gen_inc    = ram_rdata + GEN_BITS'(1);
  assign rd_ext     = CmpW'(ram_rdata);
  assign inc_ext    = CmpW'(gen_inc);
  assign hgen_ext   = CmpW'(hgen_q);
  assign handle_ok  = (slot_q != '0)
                   && ({1'b0, slot_q} < (SlotW + 1)'(hw_q))
                   && alive_q[slot_idx]
                   && (rd_ext == hgen_ext);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((op_in == OP_END_FRAME || op_in == OP_KILL_ALL) && sel_in != '0) begin
            state_d = S_SWEEP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC:  state_d = S_IDLE;
      S_SWEEP: if (pend_q && pend_last_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr   = (state_q == S_SWEEP) ? sel_idx
                : (op_in == OP_SPAWN) ? free_idx : slot_index_i[IdxW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = tgt_q;
    ram_wdata   = gen_inc;
    exec_status = ST_INVALID;
    exec_slot   = '0;
    exec_gen    = '0;
    if (state_q == S_EXEC) begin
      unique case (op_q)
        OP_SPAWN: begin
          if (reuse_q) begin
            ram_we      = 1'b1;
            exec_status = ST_OK;
            exec_slot   = SlotW'(tgt_q);
            exec_gen    = inc_ext[GenOutW-1:0];
          end else if (can_append) begin
            ram_we      = 1'b1;
            ram_waddr   = hw_idx;
            ram_wdata   = '0;
            exec_status = ST_OK;
            exec_slot   = SlotW'(hw_idx);
          end else begin
            exec_status = ST_FULL;
          end
        end
        OP_LOOKUP, OP_KILL, OP_DEFER: begin
          if (handle_ok) begin
            exec_status = ST_OK;
            exec_slot   = slot_q;
            exec_gen    = rd_ext[GenOutW-1:0];
          end
        end
        OP_END_FRAME, OP_KILL_ALL: exec_status = ST_NOTHING;
        default: exec_status = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alive_q     <= '0;
      marked_q    <= '0;
      sel_q       <= '0;
      hw_q        <= HwW'(1);
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC) || ((state_q == S_SWEEP) && pend_q);
      if (accept) begin
        sel_q <= sel_in;
      end
      if (state_q == S_EXEC) begin
        case (op_q)
          OP_SPAWN: begin
            if (reuse_q) begin
              alive_q[tgt_q]  <= 1'b1;
              marked_q[tgt_q] <= 1'b0;
            end else if (can_append) begin
              alive_q[hw_idx]  <= 1'b1;
              marked_q[hw_idx] <= 1'b0;
              hw_q             <= hw_q + HwW'(1);
            end
          end
          OP_KILL:  if (handle_ok) alive_q[slot_idx] <= 1'b0;
          OP_DEFER: if (handle_ok) marked_q[slot_idx] <= 1'b1;
          default: ;
        endcase
      end
      pend_q <= issue;
      if (issue) begin
        sel_q            <= sel_rest;
        alive_q[sel_idx] <= 1'b0;
        if (op_q == OP_END_FRAME) marked_q[sel_idx] <= 1'b0;
        pend_last_q <= (sel_rest == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_in;
      slot_q  <= slot_index_i;
      hgen_q  <= handle_generation_i;
      tgt_q   <= free_idx;
      reuse_q <= (free_vec != '0);
    end
    if (issue) begin
      pend_slot_q <= sel_idx;
    end
    if (state_q == S_EXEC) begin
      status_q <= exec_status;
      rslot_q  <= exec_slot;
      rgen_q   <= exec_gen;
      last_q   <= 1'b1;
    end else begin
      status_q <= ST_OK;
      rslot_q  <= SlotW'(pend_slot_q);
      rgen_q   <= rd_ext[GenOutW-1:0];
      last_q   <= pend_last_q;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign result_slot_o       = rslot_q;
  assign result_generation_o = rgen_q;
  assign last_o              = last_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request did not occupy the block");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> last_o)
    else $error("error result not final");

  a_hw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hw_q != '0) && (hw_q <= HwW'(SLOTS)))
    else $error("high-water count out of range");

  a_slot0_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alive_q[0] && ((alive_q & ~below_hw) == '0))
    else $error("live slot outside allocated range");

  a_sweep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) && pend_q && pend_last_q |=> done_o && last_o && !busy)
    else $error("sweep end mismatch");

endmodule

// ===== verif/gsa_result_checker.sv =====
`timescale 1ns / 100ps

module gsa_result_checker #(
  parameter int unsigned SLOTS    = gsa_pkg::SlotsDef,
  parameter int unsigned GEN_BITS = gsa_pkg::GenBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [gsa_pkg::OpW-1:0]     operation_i,
  input  logic [gsa_pkg::SlotW-1:0]   slot_index_i,
  input  logic [gsa_pkg::GenOutW-1:0] handle_generation_i,
  input  logic                        done_i,
  input  logic [gsa_pkg::StatusW-1:0] status_i,
  input  logic [gsa_pkg::SlotW-1:0]   result_slot_i,
  input  logic [gsa_pkg::GenOutW-1:0] result_generation_i,
  input  logic                        last_i,
  output int                          failures_o,
  output int                          outstanding_o
);

  import gsa_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [GenOutW-1:0] generation;
    logic               last;
  } outcome_t;

  outcome_t            expected_outcomes[$];
  bit                  slot_alive  [64];
  bit                  slot_marked [64];
  logic [GEN_BITS-1:0] slot_gen    [64];
  int unsigned         high_water;
  int                  mismatches;
  outcome_t            want;
  outcome_t            got;

  function automatic void add_outcome(input status_e status, input int unsigned slot,
                                      input logic [GEN_BITS-1:0] gen, input logic last);
    outcome_t item;
    item.status     = status;
    item.slot       = SlotW'(slot);
    item.generation = GenOutW'(gen);
    item.last       = last;
    expected_outcomes.push_back(item);
  endfunction

  function automatic bit handle_valid(input int unsigned slot,
                                      input logic [GenOutW-1:0] hgen);
    if (slot == 0 || slot >= high_water || slot >= SLOTS) return 1'b0;
    if (!slot_alive[slot]) return 1'b0;
    return 32'(slot_gen[slot]) == 32'(hgen);
  endfunction

  task automatic predict_request(input logic [OpW-1:0] op, input int unsigned slot,
                                 input logic [GenOutW-1:0] hgen);
    int unsigned killed;
    outcome_t    tail;
    killed = 0;
    case (op)
      OP_SPAWN: begin
        for (int unsigned i = 1; i < high_water && i < SLOTS; i++) begin
          if (!slot_alive[i]) begin
            slot_gen[i]    = slot_gen[i] + 1'b1;
            slot_alive[i]  = 1'b1;
            slot_marked[i] = 1'b0;
            add_outcome(ST_OK, i, slot_gen[i], 1'b1);
            return;
          end
        end
        if (high_water < SLOTS) begin
          slot_gen[high_water]    = '0;
          slot_alive[high_water]  = 1'b1;
          slot_marked[high_water] = 1'b0;
          add_outcome(ST_OK, high_water, '0, 1'b1);
          high_water++;
        end else begin
          add_outcome(ST_FULL, 0, '0, 1'b1);
        end
      end
      OP_LOOKUP, OP_KILL, OP_DEFER: begin
        if (!handle_valid(slot, hgen)) begin
          add_outcome(ST_INVALID, 0, '0, 1'b1);
        end else begin
          if (op == OP_KILL) slot_alive[slot] = 1'b0;
          else if (op == OP_DEFER) slot_marked[slot] = 1'b1;
          add_outcome(ST_OK, slot, slot_gen[slot], 1'b1);
        end
      end
      OP_END_FRAME, OP_KILL_ALL: begin
        for (int unsigned i = 1; i < high_water && i < SLOTS; i++) begin
          if (slot_alive[i] && (op == OP_KILL_ALL || slot_marked[i])) begin
            if (op == OP_END_FRAME) slot_marked[i] = 1'b0;
            slot_alive[i] = 1'b0;
            add_outcome(ST_OK, i, slot_gen[i], 1'b0);
            killed++;
          end
        end
        if (killed == 0) begin
          add_outcome(ST_NOTHING, 0, '0, 1'b1);
        end else begin
          tail      = expected_outcomes.pop_back();
          tail.last = 1'b1;
          expected_outcomes.push_back(tail);
        end
      end
      default: add_outcome(ST_INVALID, 0, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) begin
        slot_alive[i]  = 1'b0;
        slot_marked[i] = 1'b0;
      end
      high_water = 1;
      mismatches = 0;
      expected_outcomes.delete();
      failures_o    <= 0;
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        got = '{status_i, result_slot_i, result_generation_i, last_i};
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unrequested result status=%0d slot=%0d gen=0x%h last=%b",
                     $realtime, got.status, got.slot, got.generation, got.last);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected %0d/%0d/0x%h/%b got %0d/%0d/0x%h/%b",
                       $realtime, want.status, want.slot, want.generation, want.last,
                       got.status, got.slot, got.generation, got.last);
          end
        end
      end
      if (start_i && !busy_i) predict_request(operation_i, slot_index_i, handle_generation_i);
      failures_o    <= mismatches;
      outstanding_o <= expected_outcomes.size();
    end
  end

endmodule

// ===== verif/tb_generational_slot_allocator.sv =====
`timescale 1ns / 100ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam logic [OpW-1:0] OpUnusedLo = 3'd6;
  localparam logic [OpW-1:0] OpUnusedHi = 3'd7;
  localparam int IdlePct [4] = '{0, 82, 32, 0};

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OpW-1:0]     operation_i;
  logic [SlotW-1:0]   slot_index_i;
  logic [GenOutW-1:0] handle_generation_i;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   result_slot_o;
  logic [GenOutW-1:0] result_generation_o;
  logic               last_o;

  int                 failures;
  int                 outstanding;
  int                 idle_pct;
  logic [OpW-1:0]     inflight_ops[$];
  logic [OpW-1:0]     head_op;
  bit                 live_handles [64];
  logic [GenOutW-1:0] handle_gens  [64];

  generational_slot_allocator DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .operation_i,
    .slot_index_i,
    .handle_generation_i,
    .done_o,
    .status_o,
    .result_slot_o,
    .result_generation_o,
    .last_o
  );

  gsa_result_checker result_check (
    .clk_i,
    .rst_ni,
    .start_i             (start),
    .busy_i              (busy),
    .operation_i,
    .slot_index_i,
    .handle_generation_i,
    .done_i              (done_o),
    .status_i            (status_o),
    .result_slot_i       (result_slot_o),
    .result_generation_i (result_generation_o),
    .last_i              (last_o),
    .failures_o          (failures),
    .outstanding_o       (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // track live handles to steer requests toward valid ones
  always @(posedge clk_i) begin
    if (done_o && inflight_ops.size() != 0) begin
      head_op = inflight_ops[0];
      if (last_o) void'(inflight_ops.pop_front());
      if (status_o == ST_OK) begin
        case (head_op)
          OP_SPAWN: begin
            live_handles[result_slot_o] = 1'b1;
            handle_gens[result_slot_o]  = result_generation_o;
          end
          OP_KILL, OP_END_FRAME, OP_KILL_ALL: live_handles[result_slot_o] = 1'b0;
          default: ;
        endcase
      end
    end
    if (start && !busy) inflight_ops.push_back(operation_i);
  end

  task automatic issue(input logic [OpW-1:0] op, input logic [SlotW-1:0] slot,
                       input logic [GenOutW-1:0] gen);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start               <= 1'b0;
      slot_index_i        <= SlotW'($urandom);
      handle_generation_i <= GenOutW'($urandom);
      @(posedge clk_i);
    end
    start               <= 1'b1;
    operation_i         <= op;
    slot_index_i        <= slot;
    handle_generation_i <= gen;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic issue_spawn();
    issue(OP_SPAWN, SlotW'($urandom), GenOutW'($urandom));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (inflight_ops.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_live_slot();
    int s0;
    s0 = $urandom_range(63);
    for (int k = 0; k < 64; k++) begin
      if (live_handles[(s0 + k) % 64]) return (s0 + k) % 64;
    end
    return -1;
  endfunction

  task automatic random_request();
    int unsigned        pick;
    int                 slot;
    logic [OpW-1:0]     op;
    logic [GenOutW-1:0] gen;
    pick = $urandom_range(99);
    if (pick < 30) begin
      issue_spawn();
    end else if (pick < 85) begin
      op   = (pick < 50) ? OP_LOOKUP : (pick < 68) ? OP_KILL : OP_DEFER;
      slot = pick_live_slot();
      if (slot >= 0 && $urandom_range(3) != 0) begin
        gen = handle_gens[slot];
        if ($urandom_range(9) == 0) gen = gen ^ (GenOutW'(1) << $urandom_range(15));
        issue(op, SlotW'(slot), gen);
      end else begin
        issue(op, SlotW'($urandom), GenOutW'($urandom));
      end
    end else if (pick < 92) begin
      issue(OP_END_FRAME, SlotW'($urandom), GenOutW'($urandom));
    end else if (pick < 96) begin
      issue(OP_KILL_ALL, SlotW'($urandom), GenOutW'($urandom));
    end else begin
      issue($urandom_range(1) ? OpUnusedHi : OpUnusedLo, SlotW'($urandom),
            GenOutW'($urandom));
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    start               = 1'b0;
    operation_i         = '0;
    slot_index_i        = '0;
    handle_generation_i = '0;
    idle_pct            = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_LOOKUP, 6'd0, 16'd0);
    issue(OP_KILL, 6'd63, 16'hFFFF);
    issue(OP_END_FRAME, 6'd0, 16'd0);
    issue(OP_KILL_ALL, 6'd63, 16'hFFFF);
    issue_spawn();
    issue_spawn();
    issue_spawn();
    issue(OP_LOOKUP, 6'd1, 16'd0);
    issue(OP_LOOKUP, 6'd2, 16'd1);
    issue(OP_DEFER, 6'd2, 16'd0);
    issue(OP_DEFER, 6'd3, 16'd0);
    issue(OP_KILL, 6'd3, 16'd0);
    issue(OP_KILL, 6'd3, 16'd0);
    issue(OP_END_FRAME, 6'd0, 16'd0);
    issue_spawn();
    issue_spawn();
    issue(OP_END_FRAME, 6'd63, 16'hFFFF);
    issue(OpUnusedLo, 6'd1, 16'd0);
    issue(OpUnusedHi, 6'd63, 16'hFFFF);
    issue(OP_KILL_ALL, 6'd0, 16'd0);
    issue(OP_LOOKUP, 6'd1, 16'd0);
    issue_spawn();
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = IdlePct[phase];
      if (phase == 0) begin
        repeat (66) issue_spawn();
        issue(OP_KILL_ALL, SlotW'($urandom), GenOutW'($urandom));
      end
      repeat (95) random_request();
      wait_for_results();
    end

    repeat (20) @(posedge clk_i);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gsa_pkg.sv
rtl/core/gsa_gen_ram.sv
rtl/core/generational_slot_allocator.sv
verif/gsa_result_checker.sv
verif/tb_generational_slot_allocator.sv
